[hw/rtl/chs_pkg.sv]
// Shared constants, codes and request/response types for the chained hash set.
package chs_pkg;
  localparam int KEY_W = 31;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int BC_W = 9;
  localparam int DEF_MAX_BUCKETS = 256;
  localparam int DEF_POOL_NODES = 256;
  localparam logic [BC_W-1:0] BC_RESET = 9'd256;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [KEY_W-1:0] key;
  } in_req_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [KEY_W-1:0] key_out;
  } out_rsp_t;
endpackage

[hw/rtl/chs_front.sv]
// Front end: accepts requests and computes the bucket, four remainder bits per cycle.
module chs_front #(
  parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
  parameter int BW = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  chs_pkg::in_req_t in_data,
  input  logic [chs_pkg::BC_W-1:0] bucket_count,
  input  logic hold,
  input  logic q_full,
  output logic q_push,
  output logic [chs_pkg::OP_W+chs_pkg::KEY_W+BW-1:0] q_wdata
);
  localparam int BCW = chs_pkg::BC_W;
  localparam int RW = BCW + 1;

  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [BCW-1:0] d_r, d_nxt, d_eff;
  logic [chs_pkg::OP_W-1:0] op_r, op_nxt;
  logic [chs_pkg::KEY_W-1:0] key_r, key_nxt;
  logic acc;

  assign in_stall = busy_r || hold;
  assign acc = in_valid && !in_stall;
  assign q_push = busy_r && done_r && !q_full;
  assign q_wdata = {op_r, key_r, BW'(32'(rem_r))};

  always_comb begin
    if (bucket_count == '0) d_eff = BCW'(1);
    else if (32'(bucket_count) > MAX_BUCKETS) d_eff = BCW'(MAX_BUCKETS);
    else d_eff = bucket_count;
  end

  always_comb begin
    logic [RW-1:0] r;
    logic [31:0] q;
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    op_nxt = op_r;
    key_nxt = key_r;
    r = rem_r;
    q = q_r;
    if (acc) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt = '0;
      q_nxt = {1'b0, in_data.key};
      rem_nxt = '0;
      d_nxt = d_eff;
      op_nxt = in_data.operation;
      key_nxt = in_data.key;
    end else if (busy_r && !done_r) begin
      // restoring remainder, radix 16
      for (int i = 0; i < 4; i++) begin
        r = {r[RW-2:0], q[31]};
        q = {q[30:0], 1'b0};
        if (r >= {1'b0, d_r}) r = r - {1'b0, d_r};
      end
      rem_nxt = r;
      q_nxt = q;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) done_nxt = 1'b1;
    end else if (q_push) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
    op_r <= op_nxt;
    key_r <= key_nxt;
  end
endmodule

[hw/rtl/chs_fifo.sv]
// Two-entry request queue between front and back.
module chs_fifo #(
  parameter int W = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic [W-1:0] wdata,
  input  logic pop,
  output logic [W-1:0] rdata,
  output logic full,
  output logic empty
);
  logic [W-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wdata;
  end
endmodule

[hw/rtl/chs_back.sv]
// Back end: chain walk, insert/delete over bucket heads, node keys, links and free list.
module chs_back #(
  parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
  parameter int POOL_NODES = chs_pkg::DEF_POOL_NODES,
  parameter int BW = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  logic [chs_pkg::OP_W+chs_pkg::KEY_W+BW-1:0] q_rdata,
  output logic q_pop,
  output logic clearing,
  output logic out_valid,
  input  logic out_stall,
  output chs_pkg::out_rsp_t out_data
);
  localparam int KW = chs_pkg::KEY_W;
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int NIW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int CLR_N = (MAX_BUCKETS > POOL_NODES) ? MAX_BUCKETS : POOL_NODES;
  localparam int CW = $clog2(CLR_N + 1);
  localparam logic [NW-1:0] NO_NODE = NW'(POOL_NODES);

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_HEAD = 4'd2;
  localparam logic [3:0] S_LOOK = 4'd3;
  localparam logic [3:0] S_CMP = 4'd4;
  localparam logic [3:0] S_ALLOC = 4'd5;
  localparam logic [3:0] S_DEL2 = 4'd6;
  localparam logic [3:0] S_RESP = 4'd7;

  logic [NW-1:0] heads_m [MAX_BUCKETS];
  logic [NW-1:0] links_m [POOL_NODES];
  logic [KW-1:0] keys_m [POOL_NODES];

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [chs_pkg::OP_W-1:0] op_r, op_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt;
  logic [NW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, headv_r, headv_nxt;
  logic [NW-1:0] free_r, free_nxt, steps_r, steps_nxt;
  logic [chs_pkg::ST_W-1:0] st_r, st_nxt;
  logic [KW-1:0] echo_r, echo_nxt;
  logic out_valid_r, out_valid_nxt;
  chs_pkg::out_rsp_t out_r, out_nxt;

  logic [NW-1:0] head_q, link_q;
  logic [KW-1:0] key_q;

  logic h_we, l_we, k_we;
  logic [BW-1:0] h_wa, h_ra;
  logic [NW-1:0] h_wd, l_wd;
  logic [NIW-1:0] l_wa, l_ra, k_wa, k_ra;
  logic [KW-1:0] k_wd;

  logic cur_ok, free_ok, prev_ok;

  assign clearing = state_r == S_CLR;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign q_pop = state_r == S_IDLE && !q_empty;
  assign cur_ok = 32'(cur_r) < POOL_NODES && 32'(steps_r) < POOL_NODES;
  assign free_ok = 32'(free_r) < POOL_NODES;
  assign prev_ok = 32'(prev_r) < POOL_NODES;
  assign h_ra = q_rdata[BW-1:0];
  assign l_ra = cur_ok ? cur_r[NIW-1:0] : free_r[NIW-1:0];
  assign k_ra = cur_r[NIW-1:0];

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    op_nxt = op_r;
    key_nxt = key_r;
    bkt_nxt = bkt_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    headv_nxt = headv_r;
    free_nxt = free_r;
    steps_nxt = steps_r;
    st_nxt = st_r;
    echo_nxt = echo_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    h_we = 1'b0;
    h_wa = bkt_r;
    h_wd = cur_r;
    l_we = 1'b0;
    l_wa = cur_r[NIW-1:0];
    l_wd = free_r;
    k_we = 1'b0;
    k_wa = free_r[NIW-1:0];
    k_wd = key_r;
    unique case (state_r)
      S_CLR: begin
        h_we = 32'(clr_r) < MAX_BUCKETS;
        h_wa = BW'(32'(clr_r));
        h_wd = NO_NODE;
        l_we = 32'(clr_r) < POOL_NODES;
        l_wa = NIW'(32'(clr_r));
        l_wd = NW'(32'(clr_r) + 32'd1);
        clr_nxt = clr_r + CW'(1);
        if (32'(clr_r) == CLR_N - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (!q_empty) begin
          {op_nxt, key_nxt, bkt_nxt} = q_rdata;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cur_nxt = head_q;
        headv_nxt = head_q;
        prev_nxt = NO_NODE;
        steps_nxt = '0;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        echo_nxt = '0;
        if (cur_ok) begin
          state_nxt = S_CMP;
        end else if (op_r == chs_pkg::OP_INSERT) begin
          if (free_ok) begin
            state_nxt = S_ALLOC;
          end else begin
            st_nxt = chs_pkg::ST_FULL;
            state_nxt = S_RESP;
          end
        end else begin
          st_nxt = chs_pkg::ST_ABSENT;
          state_nxt = S_RESP;
        end
      end
      S_CMP: begin
        if (key_q == key_r) begin
          state_nxt = S_RESP;
          priority case (op_r)
            chs_pkg::OP_INSERT: st_nxt = chs_pkg::ST_DUP;
            chs_pkg::OP_DELETE: begin
              if (prev_ok) begin
                l_we = 1'b1;
                l_wa = prev_r[NIW-1:0];
                l_wd = link_q;
              end else begin
                h_we = 1'b1;
                h_wd = link_q;
              end
              state_nxt = S_DEL2;
            end
            chs_pkg::OP_LOOKUP: begin
              st_nxt = chs_pkg::ST_DONE;
              echo_nxt = key_r;
            end
            default: st_nxt = chs_pkg::ST_ABSENT;
          endcase
        end else begin
          prev_nxt = cur_r;
          cur_nxt = link_q;
          steps_nxt = steps_r + NW'(1);
          state_nxt = S_LOOK;
        end
      end
      S_ALLOC: begin
        // link_q holds the free node's successor
        free_nxt = link_q;
        k_we = 1'b1;
        l_we = 1'b1;
        l_wa = free_r[NIW-1:0];
        l_wd = headv_r;
        h_we = 1'b1;
        h_wd = free_r;
        st_nxt = chs_pkg::ST_DONE;
        state_nxt = S_RESP;
      end
      S_DEL2: begin
        l_we = 1'b1;
        free_nxt = cur_r;
        st_nxt = chs_pkg::ST_DONE;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt.status = st_r;
          out_nxt.key_out = echo_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) heads_m[h_wa] <= h_wd;
    head_q <= heads_m[h_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) links_m[l_wa] <= l_wd;
    link_q <= links_m[l_ra];
  end

  always_ff @(posedge clk) begin
    if (k_we) keys_m[k_wa] <= k_wd;
    key_q <= keys_m[k_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      free_r <= '0;
      out_valid_r <= 1'b0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      free_r <= free_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r <= steps_nxt;
    end
    op_r <= op_nxt;
    key_r <= key_nxt;
    bkt_r <= bkt_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    headv_r <= headv_nxt;
    st_r <= st_nxt;
    echo_r <= echo_nxt;
    out_r <= out_nxt;
  end

  a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !q_pop) else $error("pop during clear");
  a_free_rng: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_r) <= POOL_NODES) else $error("free head out of range");
  a_steps_rng: assert property (@(posedge clk) disable iff (!rst_n)
    32'(steps_r) <= POOL_NODES) else $error("walk overran pool");
  a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP) else $error("stray response");
endmodule

[hw/rtl/chained_hash_set.sv]
// Request path: the front works out the bucket remainder at 4 bits/cycle, then pushes the
//   request to the queue; the back pops it, reads the head, checks the chain and responds,
//   with one key compare per node walked; new inserts add an allocate step, deletes a free step.
// Flow: the front takes no new request until its current one is pushed to the queue;
//   the back handles one request at a time, so chain length sets the rate.
// Reset (sync, rst_n low): bucket count 256, free list rebuilt; a clear sweep over
//   max(MAX_BUCKETS, POOL_NODES) entries follows, in_stall high throughout.
module chained_hash_set #(
  parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
  parameter int POOL_NODES = chs_pkg::DEF_POOL_NODES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  chs_pkg::in_req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output chs_pkg::out_rsp_t out_data,
  input  logic cfg_we,
  input  logic [chs_pkg::BC_W-1:0] cfg_wdata
);
  // bucket index width
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int QW = chs_pkg::OP_W + chs_pkg::KEY_W + BW;

  logic [chs_pkg::BC_W-1:0] bucket_count_r;
  logic q_push, q_pop, q_full, q_empty, clearing;
  logic [QW-1:0] q_wdata, q_rdata;

  // bucket count register; write only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= chs_pkg::BC_RESET;
    else if (cfg_we) bucket_count_r <= cfg_wdata;
  end

  // front: accept and hash
  chs_front #(.MAX_BUCKETS(MAX_BUCKETS), .BW(BW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .bucket_count(bucket_count_r), .hold(clearing),
    .q_full(q_full), .q_push(q_push), .q_wdata(q_wdata)
  );

  // decoupling queue
  chs_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_wdata), .pop(q_pop), .rdata(q_rdata),
    .full(q_full), .empty(q_empty)
  );

  // back: chain walk and update
  chs_back #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES), .BW(BW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_rdata(q_rdata), .q_pop(q_pop), .clearing(clearing),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
